FILE: rtl/espp_pkg.sv
// shared types, constants and the control program of the speed controller
package espp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CfgKp         = 3'd0;
  localparam logic [2:0] CfgKd         = 3'd1;
  localparam logic [2:0] CfgKi         = 3'd2;
  localparam logic [2:0] CfgPwmPeriod  = 3'd3;
  localparam logic [2:0] CfgSampleMs   = 3'd4;
  localparam logic [2:0] CfgDerivScale = 3'd5;

  // register reset values
  localparam logic [15:0] KpRst         = 16'd8;
  localparam logic [15:0] KdRst         = 16'd10;
  localparam logic [15:0] KiRst         = 16'd1;
  localparam logic [15:0] PwmPeriodRst  = 16'd8000;
  localparam logic [9:0]  SampleMsRst   = 10'd25;
  localparam logic [9:0]  DerivScaleRst = 10'd40;

  // integral scaling divisor (milliseconds per second)
  localparam int unsigned DivConst = 1000;
  localparam int unsigned RemW     = $clog2(DivConst);

  // the divide runs one 16-bit digit per loop pass over a 64-bit magnitude
  localparam int unsigned DigitW    = 16;
  localparam int unsigned DivDigits = 4;
  localparam int unsigned DivW      = DigitW * DivDigits;
  localparam int unsigned DivXW     = RemW + DigitW;

  // ceil(2^36 / 1000): exact digit estimate for any partial dividend below 1000 * 2^16
  localparam int unsigned RecipShift = 36;
  localparam logic [26:0] DivRecip   = 27'd68719477;

  // product width of the shared multiplier
  localparam int unsigned ProdW = 61;
  localparam int unsigned CntW  = $clog2(DivDigits);

  typedef logic [3:0]      step_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_ERR,
    MUL_KD_DS,
    MUL_GAIN_DELTA,
    MUL_KI_SM,
    MUL_GAIN_ERR
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD_PROD,
    ACC_ADD_INTEG
  } acc_op_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD_ERR,
    DP_DELTA_LD,
    DP_GAIN_LD,
    DP_DIV_LOAD,
    DP_DIV_EST,
    DP_DIV_STEP,
    DP_DIV_SIGN,
    DP_INTEG_ADD,
    DP_CLAMP
  } dp_op_e;

  // one control word
  typedef struct packed {
    mul_op_e mul_op;
    acc_op_e acc_op;
    dp_op_e  dp_op;
    logic    cnt_load;
    logic    jump;
    step_t   target;
    logic    last;
  } ucw_t;

  localparam ucw_t UcwNop = '{
    mul_op:   MUL_NONE,
    acc_op:   ACC_NONE,
    dp_op:    DP_NONE,
    cnt_load: 1'b0,
    jump:     1'b0,
    target:   4'd0,
    last:     1'b0
  };

  localparam step_t StepDivLoop = 4'd9;

  // control program of one sample tick
  function automatic ucw_t ucode_rom(input step_t addr);
    ucw_t w;
    w = UcwNop;
    unique case (addr)
      4'd0:  w.dp_op = DP_LOAD_ERR;
      4'd1: begin
        w.mul_op = MUL_KP_ERR;
        w.dp_op  = DP_DELTA_LD;
      end
      4'd2: begin
        w.acc_op = ACC_ADD_PROD;
        w.mul_op = MUL_KD_DS;
      end
      4'd3:  w.dp_op = DP_GAIN_LD;
      4'd4:  w.mul_op = MUL_GAIN_DELTA;
      4'd5: begin
        w.acc_op = ACC_ADD_PROD;
        w.mul_op = MUL_KI_SM;
      end
      4'd6:  w.dp_op = DP_GAIN_LD;
      4'd7:  w.mul_op = MUL_GAIN_ERR;
      4'd8: begin
        w.dp_op    = DP_DIV_LOAD;
        w.cnt_load = 1'b1;
      end
      4'd9:  w.dp_op = DP_DIV_EST;
      4'd10: begin
        w.dp_op  = DP_DIV_STEP;
        w.jump   = 1'b1;
        w.target = StepDivLoop;
      end
      4'd11: w.dp_op = DP_DIV_SIGN;
      4'd12: w.dp_op = DP_INTEG_ADD;
      4'd13: w.acc_op = ACC_ADD_INTEG;
      4'd14: begin
        w.dp_op = DP_CLAMP;
        w.last  = 1'b1;
      end
      default: w = UcwNop;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/espp_seq.sv
// microprogram sequencer: step counter, loop counter and control store
module espp_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             hold_i,
  output espp_pkg::ucw_t   ctrl_o,
  output logic             busy_o
);

  logic                 busy_q, busy_d;
  espp_pkg::step_t      step_q, step_d;
  espp_pkg::cnt_t       cnt_q, cnt_d;
  espp_pkg::ucw_t       ucw;

  assign ucw    = espp_pkg::ucode_rom(step_q);
  assign ctrl_o = busy_q ? ucw : espp_pkg::UcwNop;
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      priority if (ucw.last) begin
        if (!hold_i) begin
          busy_d = 1'b0;
        end
      end else if (ucw.jump && (cnt_q != '0)) begin
        step_d = ucw.target;
        cnt_d  = cnt_q - 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
      if (ucw.cnt_load) begin
        cnt_d = espp_pkg::cnt_t'(espp_pkg::DivDigits - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: rtl/encoder_speed_pid_pwm.sv
// encoder position counter with a microcoded incremental pid speed loop driving a pwm duty
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  func_i, count_up_i, set_speed_i
//   out       source     out_valid_o/out_stall_i pwm_duty_o, measured_speed_o
//   cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// an encoder edge item is taken only while no tick is running and yields no result
// a sample tick item, once taken, occupies the sequencer for
//   13 single steps plus 4 two-step passes of the digit-wise divide by 1000
// the result lands in an output register; a new item is taken while it waits,
//   only the final step of the next tick holds while that register is still full
// asynchronous active-low reset restores the default configuration and clears the architectural state and output valid
module encoder_speed_pid_pwm (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic               count_up_i,
  input  logic signed [15:0] set_speed_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [15:0] pwm_duty_o,
  output logic signed [31:0] measured_speed_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic         [2:0] cfg_index_i,
  input  logic        [15:0] cfg_data_i
);

  localparam int unsigned PW = espp_pkg::ProdW;
  localparam int unsigned RW = espp_pkg::RemW;
  localparam int unsigned DW = espp_pkg::DivW;
  localparam int unsigned XW = espp_pkg::DivXW;

  // configuration registers
  logic [15:0] kp_q, kd_q, ki_q, period_q;
  logic [9:0]  sm_q, ds_q;

  // architectural state
  logic        [31:0] pos_q;
  logic        [31:0] last_q;
  logic signed [33:0] perr_q;
  logic signed [47:0] integ_q;
  logic        [15:0] duty_q;

  // working registers of the datapath
  logic signed [15:0]   des_q;
  logic        [31:0]   diff_q;
  logic signed [33:0]   err_q;
  logic signed [34:0]   delta_q;
  logic        [25:0]   gain_q;
  logic signed [PW-1:0] prod_q;
  logic signed [63:0]   acc_q;
  logic        [DW-1:0] div_q;
  logic        [RW-1:0] rem_q;
  logic [espp_pkg::DigitW-1:0] qd_q;
  logic                 neg_q;

  // output register
  logic               out_valid_q;
  logic        [15:0] out_duty_q;
  logic signed [31:0] out_speed_q;

  logic           in_acc, cfg_acc, tick_start, hold, fire, busy;
  espp_pkg::ucw_t ctrl;

  // handshakes
  assign in_stall_o  = busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign tick_start  = in_acc && func_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  // the final step waits while the previous result is still unclaimed
  assign hold        = out_valid_q && out_stall_i;
  assign fire        = (ctrl.dp_op == espp_pkg::DP_CLAMP) && !hold;

  assign out_valid_o      = out_valid_q;
  assign pwm_duty_o       = out_duty_q;
  assign measured_speed_o = out_speed_q;

  espp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tick_start),
    .hold_i  (hold),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // shared multiplier, 35-bit signed by 26-bit unsigned
  logic signed [34:0] mul_a;
  logic        [25:0] mul_b;
  logic signed [61:0] mul_full;

  always_comb begin
    unique case (ctrl.mul_op)
      espp_pkg::MUL_KP_ERR: begin
        mul_a = {err_q[33], err_q};
        mul_b = {10'd0, kp_q};
      end
      espp_pkg::MUL_KD_DS: begin
        mul_a = {19'd0, kd_q};
        mul_b = {16'd0, ds_q};
      end
      espp_pkg::MUL_GAIN_DELTA: begin
        mul_a = delta_q;
        mul_b = gain_q;
      end
      espp_pkg::MUL_KI_SM: begin
        mul_a = {19'd0, ki_q};
        mul_b = {16'd0, sm_q};
      end
      espp_pkg::MUL_GAIN_ERR: begin
        mul_a = {err_q[33], err_q};
        mul_b = gain_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // speed and error at the start of a tick
  logic        [31:0] diff_now;
  logic signed [33:0] err_now;

  assign diff_now = pos_q - last_q;
  assign err_now  = {{18{des_q[15]}}, des_q} - {{2{diff_now[31]}}, diff_now};

  // divide by 1000 one 16-bit digit at a time: the remainder and the next digit
  // form a partial dividend, a reciprocal multiply gives the quotient digit,
  // the following step takes back digit*1000 to leave the new remainder
  logic [PW-1:0] prod_mag;
  logic [XW-1:0] div_x;
  logic [XW+26:0] div_est;
  logic [XW-1:0] div_back;

  assign prod_mag = prod_q[PW-1] ? -prod_q : prod_q;
  assign div_x    = {rem_q, div_q[DW-1 -: espp_pkg::DigitW]};
  assign div_est  = div_x * espp_pkg::DivRecip;
  assign div_back = XW'(qd_q) * XW'(espp_pkg::DivConst);

  // integral update with 48-bit saturation
  logic signed [63:0] isum;
  logic               isum_ovf;
  logic signed [47:0] integ_sat;

  assign isum     = {{16{integ_q[47]}}, integ_q} + div_q;
  assign isum_ovf = !((&isum[63:47]) || (~|isum[63:47]));

  always_comb begin
    priority if (isum_ovf && isum[63]) begin
      integ_sat = {1'b1, 47'd0};
    end else if (isum_ovf) begin
      integ_sat = {1'b0, {47{1'b1}}};
    end else begin
      integ_sat = isum[47:0];
    end
  end

  // duty clamp: at or above the period goes to period-1 (or 1 when the period is at most 1), then nonpositive goes to 1
  logic        clamp_hi;
  logic        clamp_lo;
  logic [15:0] duty_new;

  assign clamp_hi = acc_q >= $signed({48'd0, period_q});
  assign clamp_lo = acc_q[63] || (acc_q == '0);

  always_comb begin
    priority if (clamp_hi && (period_q <= 16'd1)) begin
      duty_new = 16'd1;
    end else if (clamp_hi) begin
      duty_new = period_q - 16'd1;
    end else if (clamp_lo) begin
      duty_new = 16'd1;
    end else begin
      duty_new = acc_q[15:0];
    end
  end

  // configuration and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= espp_pkg::KpRst;
      kd_q     <= espp_pkg::KdRst;
      ki_q     <= espp_pkg::KiRst;
      period_q <= espp_pkg::PwmPeriodRst;
      sm_q     <= espp_pkg::SampleMsRst;
      ds_q     <= espp_pkg::DerivScaleRst;
      pos_q    <= '0;
      last_q   <= '0;
      perr_q   <= '0;
      integ_q  <= '0;
      duty_q   <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          espp_pkg::CfgKp:         kp_q     <= cfg_data_i;
          espp_pkg::CfgKd:         kd_q     <= cfg_data_i;
          espp_pkg::CfgKi:         ki_q     <= cfg_data_i;
          espp_pkg::CfgPwmPeriod:  period_q <= cfg_data_i;
          espp_pkg::CfgSampleMs:   sm_q     <= cfg_data_i[9:0];
          espp_pkg::CfgDerivScale: ds_q     <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      // encoder edge
      if (in_acc && !func_i) begin
        pos_q <= count_up_i ? pos_q + 32'd1 : pos_q - 32'd1;
      end
      if (ctrl.dp_op == espp_pkg::DP_LOAD_ERR) begin
        last_q <= pos_q;
      end
      if (ctrl.dp_op == espp_pkg::DP_DELTA_LD) begin
        perr_q <= err_q;
      end
      if (ctrl.dp_op == espp_pkg::DP_INTEG_ADD) begin
        integ_q <= integ_sat;
      end
      if (fire) begin
        duty_q <= duty_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (tick_start) begin
      des_q <= set_speed_i;
    end
    if (ctrl.mul_op != espp_pkg::MUL_NONE) begin
      prod_q <= mul_full[PW-1:0];
    end
    unique case (ctrl.acc_op)
      espp_pkg::ACC_ADD_PROD:  acc_q <= acc_q + {{(64-PW){prod_q[PW-1]}}, prod_q};
      espp_pkg::ACC_ADD_INTEG: acc_q <= acc_q + {{16{integ_q[47]}}, integ_q};
      default: ;
    endcase
    unique case (ctrl.dp_op)
      espp_pkg::DP_LOAD_ERR: begin
        diff_q <= diff_now;
        err_q  <= err_now;
        acc_q  <= {48'd0, duty_q};
      end
      espp_pkg::DP_DELTA_LD: delta_q <= {err_q[33], err_q} - {perr_q[33], perr_q};
      espp_pkg::DP_GAIN_LD:  gain_q  <= prod_q[25:0];
      espp_pkg::DP_DIV_LOAD: begin
        // divide the magnitude, sign restored afterwards
        neg_q <= prod_q[PW-1];
        div_q <= DW'(prod_mag);
        rem_q <= '0;
      end
      espp_pkg::DP_DIV_EST: qd_q <= div_est[espp_pkg::RecipShift +: espp_pkg::DigitW];
      espp_pkg::DP_DIV_STEP: begin
        rem_q <= RW'(div_x - div_back);
        div_q <= {div_q[DW-espp_pkg::DigitW-1:0], qd_q};
      end
      espp_pkg::DP_DIV_SIGN: begin
        if (neg_q) begin
          div_q <= -div_q;
        end
      end
      default: ;
    endcase
    if (fire) begin
      out_duty_q  <= duty_new;
      out_speed_q <= diff_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
